// ===== rtl/vmc_pkg.sv =====
// vmc_pkg: constants, register map and status codes for vector_magnitude_clamp.
// No dependencies.
package vmc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COEF_WIDTH      = 31;
  localparam int DATA_WIDTH      = 32;
  localparam int ADDR_WIDTH      = 3;

  localparam logic [ADDR_WIDTH-1:0] ADDR_MIN_LENGTH = 3'd0;
  localparam logic [ADDR_WIDTH-1:0] ADDR_MAX_LENGTH = 3'd4;

  localparam logic [COEF_WIDTH-1:0] MIN_LENGTH_RESET = '0;
  localparam logic [COEF_WIDTH-1:0] MAX_LENGTH_RESET = '1;

  typedef enum logic [1:0] {
    ST_PASS = 2'd0,
    ST_MAX  = 2'd1,
    ST_MIN  = 2'd2
  } status_t;

endpackage

// ===== rtl/vector_magnitude_clamp.sv =====
// vector_magnitude_clamp: limits the length of a 2D fixed-point vector to [min, max].
// Pipelined squares, bit-per-stage square root and bit-per-stage divider.
// Depends on vmc_pkg.
//
//   channel  | transfer                               | payload
//   ---------+----------------------------------------+---------------------------------
//   input    | start && !busy at rising edge          | in_x_in, in_y_in
//   result   | out_valid for one cycle, no backpressure| out_x_out, out_y_out, out_limit_status
//   config   | psel && penable && pwrite && pready    | paddr, pwdata (prdata on reads)
//
// The pipeline has one stage per root bit and one per quotient bit. One vector enters
// every cycle; busy stays low.
// Reset clears the valid bits and loads min_length = 0, max_length = all ones.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module vector_magnitude_clamp #(
  parameter int VALUE_WIDTH = vmc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [VALUE_WIDTH-1:0]       in_x_in,
  input  logic signed [VALUE_WIDTH-1:0]       in_y_in,
  output logic                                out_valid,
  output logic signed [VALUE_WIDTH-1:0]       out_x_out,
  output logic signed [VALUE_WIDTH-1:0]       out_y_out,
  output logic [1:0]                          out_limit_status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vmc_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [vmc_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [vmc_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                pready
);

  localparam int W  = VALUE_WIDTH;
  localparam int H  = W / 2;
  localparam int HW = W - H;
  localparam int CW = vmc_pkg::COEF_WIDTH;
  localparam int SW = 2 * W + 2;
  localparam int NS = W + 1;
  localparam int RW = W + 4;
  localparam int P  = W + CW;
  localparam int MW = (W > CW) ? W : CW;
  localparam int EW = MW + 1;

  // configuration
  logic [CW-1:0] min_r;
  logic [CW-1:0] max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= vmc_pkg::MIN_LENGTH_RESET;
      max_r <= vmc_pkg::MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr)
        vmc_pkg::ADDR_MIN_LENGTH: min_r <= pwdata[CW-1:0];
        vmc_pkg::ADDR_MAX_LENGTH: max_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      vmc_pkg::ADDR_MIN_LENGTH: prdata = vmc_pkg::DATA_WIDTH'(min_r);
      vmc_pkg::ADDR_MAX_LENGTH: prdata = vmc_pkg::DATA_WIDTH'(max_r);
      default:                  prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // stage A: magnitudes
  logic         a_v_r;
  logic [W-1:0] a_mx_r, a_my_r;
  logic         a_nx_r, a_ny_r;
  logic [W-1:0] xu, yu;

  assign xu = in_x_in;
  assign yu = in_y_in;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    a_nx_r <= xu[W-1];
    a_ny_r <= yu[W-1];
    a_mx_r <= xu[W-1] ? (~xu + W'(1)) : xu;
    a_my_r <= yu[W-1] ? (~yu + W'(1)) : yu;
  end

  // stage B: partial products of the squares
  logic              b_v_r;
  logic [W-1:0]      b_mx_r, b_my_r;
  logic              b_nx_r, b_ny_r;
  logic [2*HW-1:0]   b_xhh_r, b_yhh_r;
  logic [W-1:0]      b_xhl_r, b_yhl_r;
  logic [2*H-1:0]    b_xll_r, b_yll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else        b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    b_mx_r  <= a_mx_r;
    b_my_r  <= a_my_r;
    b_nx_r  <= a_nx_r;
    b_ny_r  <= a_ny_r;
    b_xhh_r <= a_mx_r[W-1:H] * a_mx_r[W-1:H];
    b_xhl_r <= a_mx_r[W-1:H] * a_mx_r[H-1:0];
    b_xll_r <= a_mx_r[H-1:0] * a_mx_r[H-1:0];
    b_yhh_r <= a_my_r[W-1:H] * a_my_r[W-1:H];
    b_yhl_r <= a_my_r[W-1:H] * a_my_r[H-1:0];
    b_yll_r <= a_my_r[H-1:0] * a_my_r[H-1:0];
  end

  logic [SW-1:0] sq_x, sq_y;

  assign sq_x = (SW'(b_xhh_r) << (2 * H)) + (SW'(b_xhl_r) << (H + 1)) + SW'(b_xll_r);
  assign sq_y = (SW'(b_yhh_r) << (2 * H)) + (SW'(b_yhl_r) << (H + 1)) + SW'(b_yll_r);

  // square root, one root bit per stage; index 0 holds the radicand
  logic          sr_v    [0:NS];
  logic [SW-1:0] sr_rad  [0:NS];
  logic [RW-1:0] sr_rem  [0:NS];
  logic [W:0]    sr_root [0:NS];
  logic [W-1:0]  sr_mx   [0:NS];
  logic [W-1:0]  sr_my   [0:NS];
  logic          sr_nx   [0:NS];
  logic          sr_ny   [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) sr_v[0] <= 1'b0;
    else        sr_v[0] <= b_v_r;
  end

  always_ff @(posedge clk) begin
    sr_rad[0]  <= sq_x + sq_y;
    sr_rem[0]  <= '0;
    sr_root[0] <= '0;
    sr_mx[0]   <= b_mx_r;
    sr_my[0]   <= b_my_r;
    sr_nx[0]   <= b_nx_r;
    sr_ny[0]   <= b_ny_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;

    assign t     = {sr_rem[i][RW-3:0], sr_rad[i][SW-1-2*i -: 2]};
    assign trial = RW'({sr_root[i], 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sr_v[i+1] <= 1'b0;
      else        sr_v[i+1] <= sr_v[i];
    end

    always_ff @(posedge clk) begin
      sr_rad[i+1]  <= sr_rad[i];
      sr_rem[i+1]  <= ge ? (t - trial) : t;
      sr_root[i+1] <= {sr_root[i][W-1:0], ge};
      sr_mx[i+1]   <= sr_mx[i];
      sr_my[i+1]   <= sr_my[i];
      sr_nx[i+1]   <= sr_nx[i];
      sr_ny[i+1]   <= sr_ny[i];
    end
  end

  // stage C1: limit decision
  logic [W-1:0]     len;
  logic             too_long, too_short;
  vmc_pkg::status_t st_nxt;
  logic [CW-1:0]    coef_nxt;

  assign len       = sr_root[NS][W-1:0];
  assign too_long  = MW'(len) > MW'(max_r);
  assign too_short = MW'(len) < MW'(min_r);

  always_comb begin
    st_nxt   = vmc_pkg::ST_PASS;
    coef_nxt = max_r;
    if (len == '0) begin
      st_nxt = vmc_pkg::ST_PASS;
    end else if (too_long) begin
      st_nxt = vmc_pkg::ST_MAX;
    end else if (too_short) begin
      st_nxt   = vmc_pkg::ST_MIN;
      coef_nxt = min_r;
    end
  end

  logic             c_v_r;
  vmc_pkg::status_t c_st_r;
  logic [CW-1:0]    c_coef_r;
  logic [W-1:0]     c_len_r, c_mx_r, c_my_r;
  logic             c_nx_r, c_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else        c_v_r <= sr_v[NS];
  end

  always_ff @(posedge clk) begin
    c_st_r   <= st_nxt;
    c_coef_r <= coef_nxt;
    c_len_r  <= len;
    c_mx_r   <= sr_mx[NS];
    c_my_r   <= sr_my[NS];
    c_nx_r   <= sr_nx[NS];
    c_ny_r   <= sr_ny[NS];
  end

  // stage C2: partial products magnitude * coef
  logic             p_v_r;
  vmc_pkg::status_t p_st_r;
  logic [W-1:0]     p_len_r, p_mx_r, p_my_r;
  logic             p_nx_r, p_ny_r;
  logic [HW+CW-1:0] p_xh_r, p_yh_r;
  logic [H+CW-1:0]  p_xl_r, p_yl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else        p_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    p_st_r  <= c_st_r;
    p_len_r <= c_len_r;
    p_mx_r  <= c_mx_r;
    p_my_r  <= c_my_r;
    p_nx_r  <= c_nx_r;
    p_ny_r  <= c_ny_r;
    p_xh_r  <= c_mx_r[W-1:H] * c_coef_r;
    p_xl_r  <= c_mx_r[H-1:0] * c_coef_r;
    p_yh_r  <= c_my_r[W-1:H] * c_coef_r;
    p_yl_r  <= c_my_r[H-1:0] * c_coef_r;
  end

  logic [P-1:0] dend_x, dend_y;

  assign dend_x = (P'(p_xh_r) << H) + P'(p_xl_r);
  assign dend_y = (P'(p_yh_r) << H) + P'(p_yl_r);

  // divider, one quotient bit per stage; the quotient never exceeds coef
  logic             dv_v     [0:CW];
  vmc_pkg::status_t dv_st    [0:CW];
  logic [W-1:0]     dv_len   [0:CW];
  logic [W-1:0]     dv_mx    [0:CW];
  logic [W-1:0]     dv_my    [0:CW];
  logic             dv_nx    [0:CW];
  logic             dv_ny    [0:CW];
  logic [W-1:0]     dv_xrem  [0:CW];
  logic [W-1:0]     dv_yrem  [0:CW];
  logic [CW-1:0]    dv_xlo   [0:CW];
  logic [CW-1:0]    dv_ylo   [0:CW];
  logic [CW-1:0]    dv_xq    [0:CW];
  logic [CW-1:0]    dv_yq    [0:CW];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v[0] <= 1'b0;
    else        dv_v[0] <= p_v_r;
  end

  always_ff @(posedge clk) begin
    dv_st[0]   <= p_st_r;
    dv_len[0]  <= p_len_r;
    dv_mx[0]   <= p_mx_r;
    dv_my[0]   <= p_my_r;
    dv_nx[0]   <= p_nx_r;
    dv_ny[0]   <= p_ny_r;
    dv_xrem[0] <= dend_x[P-1:CW];
    dv_yrem[0] <= dend_y[P-1:CW];
    dv_xlo[0]  <= dend_x[CW-1:0];
    dv_ylo[0]  <= dend_y[CW-1:0];
    dv_xq[0]   <= '0;
    dv_yq[0]   <= '0;
  end

  for (genvar j = 0; j < CW; j++) begin : g_div
    logic [W:0] tx, ty, dl;
    logic       gx, gy;
    logic [W:0] sx, sy;

    assign dl = {1'b0, dv_len[j]};
    assign tx = {dv_xrem[j], dv_xlo[j][CW-1-j]};
    assign ty = {dv_yrem[j], dv_ylo[j][CW-1-j]};
    assign gx = tx >= dl;
    assign gy = ty >= dl;
    assign sx = gx ? (tx - dl) : tx;
    assign sy = gy ? (ty - dl) : ty;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v[j+1] <= 1'b0;
      else        dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      dv_st[j+1]   <= dv_st[j];
      dv_len[j+1]  <= dv_len[j];
      dv_mx[j+1]   <= dv_mx[j];
      dv_my[j+1]   <= dv_my[j];
      dv_nx[j+1]   <= dv_nx[j];
      dv_ny[j+1]   <= dv_ny[j];
      dv_xlo[j+1]  <= dv_xlo[j];
      dv_ylo[j+1]  <= dv_ylo[j];
      dv_xrem[j+1] <= sx[W-1:0];
      dv_yrem[j+1] <= sy[W-1:0];
      dv_xq[j+1]   <= {dv_xq[j][CW-2:0], gx};
      dv_yq[j+1]   <= {dv_yq[j][CW-2:0], gy};
    end
  end

  // output stage: pick scaled or original magnitude, restore sign
  logic [EW-1:0] vx, vy, rx, ry;

  assign vx = (dv_st[CW] == vmc_pkg::ST_PASS) ? EW'(dv_mx[CW]) : EW'(dv_xq[CW]);
  assign vy = (dv_st[CW] == vmc_pkg::ST_PASS) ? EW'(dv_my[CW]) : EW'(dv_yq[CW]);
  assign rx = dv_nx[CW] ? (~vx + EW'(1)) : vx;
  assign ry = dv_ny[CW] ? (~vy + EW'(1)) : vy;

  logic         o_v_r;
  logic [W-1:0] o_x_r, o_y_r;
  logic [1:0]   o_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else        o_v_r <= dv_v[CW];
  end

  always_ff @(posedge clk) begin
    o_x_r  <= rx[W-1:0];
    o_y_r  <= ry[W-1:0];
    o_st_r <= dv_st[CW];
  end

  assign out_valid        = o_v_r;
  assign out_x_out        = o_x_r;
  assign out_y_out        = o_y_r;
  assign out_limit_status = o_st_r;

endmodule

// ===== verif/vector_magnitude_clamp_tb.sv =====
// vector_magnitude_clamp_tb: self-checking testbench for vector_magnitude_clamp.
// Predicts length limiting with exact wide arithmetic; register writes over APB.
// Depends on vmc_pkg and rtl/vector_magnitude_clamp.sv.
class clamp_scoreboard;
  logic [30:0] min_len;
  logic [30:0] max_len;
  logic [31:0] want_x[$];
  logic [31:0] want_y[$];
  vmc_pkg::status_t want_st[$];
  int errors;

  function new();
    min_len = vmc_pkg::MIN_LENGTH_RESET;
    max_len = vmc_pkg::MAX_LENGTH_RESET;
    errors = 0;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] rescale(logic [31:0] v, logic [30:0] coef, logic [63:0] len);
    logic [31:0] m32;
    logic [63:0] mag;
    logic [127:0] q;
    m32 = v[31] ? ((~v) + 32'd1) : v;
    mag = {32'd0, m32};
    q = (128'(mag) * 128'(coef)) / 128'(len);
    return v[31] ? -q[31:0] : q[31:0];
  endfunction

  function void note_vector(logic [31:0] x, logic [31:0] y);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] len;
    ax = x[31] ? ((~x) + 32'd1) : x;
    ay = y[31] ? ((~y) + 32'd1) : y;
    mx = {32'd0, ax};
    my = {32'd0, ay};
    len = isqrt(128'(mx) * 128'(mx) + 128'(my) * 128'(my));
    if (len != 0 && len > max_len) begin
      want_x.push_back(rescale(x, max_len, len));
      want_y.push_back(rescale(y, max_len, len));
      want_st.push_back(vmc_pkg::ST_MAX);
    end else if (len != 0 && len < min_len) begin
      want_x.push_back(rescale(x, min_len, len));
      want_y.push_back(rescale(y, min_len, len));
      want_st.push_back(vmc_pkg::ST_MIN);
    end else begin
      want_x.push_back(x);
      want_y.push_back(y);
      want_st.push_back(vmc_pkg::ST_PASS);
    end
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [31:0] x, logic [31:0] y, logic [1:0] st);
    logic [31:0] ex;
    logic [31:0] ey;
    vmc_pkg::status_t es;
    if (want_x.size() == 0) begin
      report("result with nothing pending");
      return;
    end
    ex = want_x.pop_front();
    ey = want_y.pop_front();
    es = want_st.pop_front();
    if (x !== ex) report($sformatf("x_out %h, wanted %h", x, ex));
    if (y !== ey) report($sformatf("y_out %h, wanted %h", y, ey));
    if (st !== es) report($sformatf("limit_status %0d, wanted %0d", st, es));
  endtask
endclass

module vector_magnitude_clamp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 71;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_x_in;
  logic signed [31:0] in_y_in;
  logic out_valid;
  logic signed [31:0] out_x_out;
  logic signed [31:0] out_y_out;
  logic [1:0] out_limit_status;
  logic psel;
  logic penable;
  logic pwrite;
  logic [vmc_pkg::ADDR_WIDTH-1:0] paddr;
  logic [vmc_pkg::DATA_WIDTH-1:0] pwdata;
  logic [vmc_pkg::DATA_WIDTH-1:0] prdata;
  logic pready;
  longint cycles;
  clamp_scoreboard sb;

  vector_magnitude_clamp uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_x_out, out_y_out, out_limit_status);

  task automatic write_reg(logic [vmc_pkg::ADDR_WIDTH-1:0] addr, logic [31:0] val);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= val; penable <= 0;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (addr == vmc_pkg::ADDR_MIN_LENGTH) sb.min_len = val[30:0];
    if (addr == vmc_pkg::ADDR_MAX_LENGTH) sb.max_len = val[30:0];
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(negedge clk);
  endtask

  // start stays high after the transfer so back-to-back vectors need no gap
  task automatic send_vector(logic [31:0] x, logic [31:0] y, int gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1; in_x_in <= x; in_y_in <= y;
    do @(posedge clk); while (busy);
    sb.note_vector(x, y);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.want_x.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return 32'($signed($urandom_range(0, 64)) - 32);
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int count, logic [30:0] lo, logic [30:0] hi);
    logic [31:0] x;
    logic [31:0] y;
    write_reg(vmc_pkg::ADDR_MIN_LENGTH, {1'b0, lo});
    write_reg(vmc_pkg::ADDR_MAX_LENGTH, {$urandom_range(0, 1) ? 1'b1 : 1'b0, hi});
    for (int i = 0; i < count; i++) begin
      x = rand_comp();
      y = rand_comp();
      send_vector(x, y, (i % 50 < 15) ? 0 : $urandom_range(0, 19));
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst_n = 0; start = 0; in_x_in = 0; in_y_in = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 0);
    send_vector(0, 0, 0);
    send_vector(32'h8000_0000, 0, 1);
    drain();
    write_reg(vmc_pkg::ADDR_MIN_LENGTH, 32'h0001_0000);
    write_reg(vmc_pkg::ADDR_MAX_LENGTH, 32'h0010_0000);
    send_vector(0, 0, 0);
    send_vector(32'h0000_0003, 32'hffff_fffc, 0);
    send_vector(32'h0100_0000, 32'hff00_0000, 0);
    send_vector(32'h8000_0000, 32'h7fff_ffff, 0);
    send_vector(32'h0008_0000, 32'h0000_0000, 2);
    send_vector(32'h0000_0001, 32'h0000_0000, 0);
    drain();
    // min above max: the max bound wins
    write_reg(vmc_pkg::ADDR_MIN_LENGTH, 32'hffff_ffff);
    write_reg(vmc_pkg::ADDR_MAX_LENGTH, 32'h0000_0100);
    send_vector(32'h0000_0200, 32'h0000_0200, 0);
    send_vector(32'h0000_0010, 32'hffff_fff0, 0);
    send_vector(32'h8000_0000, 32'h0000_0001, 0);
    drain();
    write_reg(vmc_pkg::ADDR_MAX_LENGTH, 32'h0000_0000);
    write_reg(vmc_pkg::ADDR_MIN_LENGTH, 32'h0000_0000);
    send_vector(32'h0000_0005, 32'h0000_0007, 0);
    send_vector(32'h7fff_ffff, 32'h8000_0000, 0);
    drain();

    run_random(150, 31'h0, 31'h7fff_ffff);
    run_random(150, 31'($urandom_range(0, 2000000)), 31'($urandom_range(0, 100000000)));
    run_random(150, 31'h7fff_ffff, 31'h7fff_ffff);
    run_random(150, 31'($urandom), 31'($urandom));
    run_random(150, 31'h0000_0040, 31'h0);

    if (sb.errors == 0 && sb.want_x.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.want_x.size() != 0) sb.report("results still pending at end");
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
